[rtl/ffpa_pkg.sv]
// shared types and constants for the first-fit page allocator
// no dependencies; imported by first_fit_page_allocator_core and its bench
package ffpa_pkg;

    localparam int          MAX_PAGES_DEF    = 8;
    localparam int          FILL_W           = 30;
    localparam logic [31:0] PAGE_BYTES_RESET = 32'd134217728;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // result status codes
    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_TOO_BIG  = 2'd1;
    localparam logic [1:0] ST_NO_PAGE  = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    typedef struct packed {
        logic        cmd;
        logic [31:0] block_bytes;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [2:0]        page_index;
        logic [FILL_W-1:0] word_offset;
    } t_out;

endpackage

[rtl/ffpa_ram.sv]
// generic single-clock ram, one write port, one read port, registered read
// depends on nothing
module ffpa_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/first_fit_page_allocator_core.sv]
// first-fit page allocator: places word-rounded blocks into up to MAX_PAGES pages
// depends on ffpa_pkg and ffpa_ram (page fill counts live in the ram)
//
//  channel | handshake                      | beat
//  --------+--------------------------------+---------------------------------
//  in      | i_in_valid  / o_in_stall       | i_in_data  (cmd, block_bytes)
//  out     | o_out_valid / i_out_stall      | o_out_data (status, page, offset)
//  cfg     | i_cfg_valid / o_cfg_ready      | i_cfg_data (max_page_bytes)
//
// clear, oversize and first-page-open beats go from accept straight to the done state.
// an allocate that scans open pages holds in the check state, one ram read per page,
// until one fits or the list ends (at most MAX_PAGES pages), then goes to done.
// reset clears the page count but not the fill ram; fill entries past the count are never read.
// a result held in a stalled output register keeps the block in done and stalls the next input beat.
module first_fit_page_allocator_core #(
    parameter int MAX_PAGES = ffpa_pkg::MAX_PAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ffpa_pkg::t_in       i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ffpa_pkg::t_out      o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [31:0]         i_cfg_data
);
    import ffpa_pkg::*;

    localparam int IDX_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PO_W  = IDX_W + 1;
    localparam logic [PO_W-1:0] PAGES_MAX = PO_W'(MAX_PAGES);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [31:0]        r_cap;
    logic [PO_W-1:0]    r_pages_open, n_pages_open;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [30:0]        r_words, n_words;
    t_out               r_res, n_res;
    logic               r_out_valid;
    t_out               r_out;

    logic               in_acc;
    logic               out_free;
    logic [30:0]        in_words;
    logic [29:0]        cap_words;
    logic [FILL_W-1:0]  fill_rd;
    logic [31:0]        fit_sum;
    logic               fits;
    logic [PO_W-1:0]    idx_next;
    logic               ram_we, ram_re;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    logic [FILL_W-1:0]  ram_wdata;
    logic [IDX_W+2:0]   idx_wide;
    logic [IDX_W+2:0]   open_wide;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // bytes rounded up to words, page capacity in whole words
    assign in_words  = {1'b0, i_in_data.block_bytes[31:2]} + 31'(|i_in_data.block_bytes[1:0]);
    assign cap_words = r_cap[31:2];

    // fit test against the page read last cycle, in words with no wrap
    assign fit_sum  = {2'b00, fill_rd} + {1'b0, r_words};
    assign fits     = fit_sum <= {2'b00, cap_words};
    assign idx_next = {1'b0, r_idx} + PO_W'(1);

    // page numbers cut to the 3-bit result field
    assign idx_wide  = {3'b000, r_idx};
    assign open_wide = {3'b000, r_pages_open[IDX_W-1:0]};

    ffpa_ram #(
        .WIDTH (FILL_W),
        .DEPTH (MAX_PAGES)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (fill_rd)
    );

    // sequencer: accept, scan open pages one read per cycle where needed, then hand off result
    always_comb begin
        n_state      = r_state;
        n_pages_open = r_pages_open;
        n_idx        = r_idx;
        n_words      = r_words;
        n_res        = r_res;
        ram_we       = 1'b0;
        ram_waddr    = r_idx;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_words = in_words;
                    n_res   = '0;
                    n_idx   = '0;
                    if (i_in_data.cmd == CMD_CLEAR) begin
                        n_pages_open = '0;
                        n_res.status = ST_CLEARED;
                        n_state      = S_DONE;
                    end else if (in_words > {1'b0, cap_words}) begin
                        n_res.status = ST_TOO_BIG;
                        n_state      = S_DONE;
                    end else if (r_pages_open == '0) begin
                        // open page zero directly
                        ram_we       = 1'b1;
                        ram_waddr    = '0;
                        ram_wdata    = in_words[FILL_W-1:0];
                        n_pages_open = PO_W'(1);
                        n_res.status = ST_PLACED;
                        n_state      = S_DONE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        n_state   = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                priority if (fits) begin
                    ram_we            = 1'b1;
                    ram_waddr         = r_idx;
                    ram_wdata         = FILL_W'(fit_sum);
                    n_res.status      = ST_PLACED;
                    n_res.page_index  = idx_wide[2:0];
                    n_res.word_offset = fill_rd;
                    n_state           = S_DONE;
                end else if (idx_next < r_pages_open) begin
                    n_idx     = idx_next[IDX_W-1:0];
                    ram_re    = 1'b1;
                    ram_raddr = idx_next[IDX_W-1:0];
                end else if (r_pages_open >= PAGES_MAX) begin
                    n_res.status = ST_NO_PAGE;
                    n_state      = S_DONE;
                end else begin
                    // open the next page
                    ram_we           = 1'b1;
                    ram_waddr        = r_pages_open[IDX_W-1:0];
                    ram_wdata        = r_words[FILL_W-1:0];
                    n_pages_open     = r_pages_open + PO_W'(1);
                    n_res.status     = ST_PLACED;
                    n_res.page_index = open_wide[2:0];
                    n_state          = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pages_open <= '0;
            r_cap        <= PAGE_BYTES_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pages_open <= n_pages_open;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_words <= n_words;
        r_res   <= n_res;
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_pages_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pages_open <= PAGES_MAX)
        else $error("page count past limit");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.cmd == CMD_CLEAR |=> r_pages_open == '0)
        else $error("clear left pages open");

    a_unplaced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_PLACED
            |-> o_out_data.page_index == '0 && o_out_data.word_offset == '0)
        else $error("unplaced result carries page or offset");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CHECK |-> {1'b0, r_idx} < r_pages_open)
        else $error("scan index beyond open pages");
`endif

endmodule

[tb/tb_top.sv]
// self-checking bench for first_fit_page_allocator_core: directed table, then random phases
// depends on ffpa_pkg and the allocator rtl; results are checked against an in-bench
// first-fit placement predictor, with random idling on both sides and a long output hold
module tb_top;
    import ffpa_pkg::*;

    // directed row: beat plus an optional hand-typed result
    typedef struct packed {
        logic              cmd;
        logic [31:0]       bytes;
        logic              typed;
        logic [1:0]        status;
        logic [2:0]        page;
        logic [FILL_W-1:0] offset;
    } t_row;

    localparam int N_ROWS   = 22;
    localparam int N_PHASES = 8;
    localparam int PHASE_SZ = 110;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    // predictor state
    logic [31:0]       page_cap;
    logic [FILL_W-1:0] page_fill [MAX_PAGES_DEF];
    int                pages_in_use;

    t_out placements_due [$];
    int   results_seen;
    int   bad_results;
    bit   tx_quiet;
    bit   rx_quiet;

    first_fit_page_allocator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // first-fit placement of one beat, updating the page fill state
    function automatic t_out place_block(input t_in beat);
        t_out        res;
        logic [33:0] need;
        logic [33:0] cap;
        int          pg;
        bit          found;
        res   = '0;
        cap   = {2'b00, page_cap};
        need  = ({2'b00, beat.block_bytes} + 34'd3) & ~34'd3;
        found = 1'b0;
        pg    = 0;
        if (beat.cmd == CMD_CLEAR) begin
            foreach (page_fill[j]) page_fill[j] = '0;
            pages_in_use = 0;
            res.status   = ST_CLEARED;
        end else if (need > cap) begin
            res.status = ST_TOO_BIG;
        end else begin
            // lowest open page with room, compared at full width
            for (int j = 0; j < pages_in_use; j++) begin
                if (!found && (need + {2'b00, page_fill[j], 2'b00}) <= cap) begin
                    found = 1'b1;
                    pg    = j;
                end
            end
            if (!found && pages_in_use >= MAX_PAGES_DEF) begin
                res.status = ST_NO_PAGE;
            end else begin
                if (!found) begin
                    pg            = pages_in_use;
                    pages_in_use  = pages_in_use + 1;
                    page_fill[pg] = '0;
                end
                res.status      = ST_PLACED;
                res.page_index  = pg[2:0];
                res.word_offset = page_fill[pg];
                page_fill[pg]   = page_fill[pg] + need[31:2];
            end
        end
        return res;
    endfunction

    // random beat, sizes mostly scaled to the current page size
    function automatic t_in draw_beat();
        t_in b;
        b.cmd = ($urandom_range(0, 24) == 0) ? CMD_CLEAR : CMD_ALLOC;
        case ($urandom_range(0, 9))
            0: b.block_bytes = $urandom();
            1: b.block_bytes = '0;
            2: b.block_bytes = page_cap - $urandom_range(0, 3);
            3: b.block_bytes = page_cap + $urandom_range(1, 4);
            4, 5, 6: b.block_bytes = $urandom_range(0, page_cap >> 3);
            default: b.block_bytes = $urandom_range(0, page_cap >> 1);
        endcase
        return b;
    endfunction

    // offer one beat after a random gap, queue its result once accepted
    task automatic offer(input t_in beat, input logic typed, input t_out typed_res);
        int   gap;
        t_out pred;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        pred = place_block(beat);
        placements_due.insert(placements_due.size(), typed ? typed_res : pred);
    endtask

    // stop offering and wait for every queued result
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
    endtask

    // page size write, block idle
    task automatic write_page_bytes(input logic [31:0] value);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        page_cap = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // stimulus
    initial begin : beat_source
        t_row        rows [N_ROWS];
        t_in         beat;
        t_out        typed_res;
        logic [31:0] caps [N_PHASES];
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        tx_quiet     = 1'b0;
        page_cap     = PAGE_BYTES_RESET;
        pages_in_use = 0;
        foreach (page_fill[j]) page_fill[j] = '0;

        // directed rows run at the reset page size of 128 MiB
        rows = '{
            '{CMD_ALLOC, 32'd0,          1'b1, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd1,          1'b1, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd4,          1'b1, ST_PLACED,  3'd0, 30'd1},
            '{CMD_ALLOC, 32'hFFFF_FFFF,  1'b1, ST_TOO_BIG, 3'd0, 30'd0},
            '{CMD_ALLOC, 32'd134217728,  1'b0, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd134217729,  1'b1, ST_TOO_BIG, 3'd0, 30'd0},
            '{CMD_CLEAR, 32'd0,          1'b1, ST_CLEARED, 3'd0, 30'd0},
            '{CMD_ALLOC, 32'd134217728,  1'b1, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd134217728,  1'b0, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd134217728,  1'b0, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd134217728,  1'b0, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd134217728,  1'b0, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd134217728,  1'b0, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd134217728,  1'b0, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd134217728,  1'b1, ST_PLACED,  3'd7, 30'd0},
            '{CMD_ALLOC, 32'd134217728,  1'b1, ST_NO_PAGE, 3'd0, 30'd0},
            '{CMD_ALLOC, 32'd0,          1'b0, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd4,          1'b1, ST_NO_PAGE, 3'd0, 30'd0},
            '{CMD_CLEAR, 32'hFFFF_FFFF,  1'b1, ST_CLEARED, 3'd0, 30'd0},
            '{CMD_ALLOC, 32'hFFFF_FFFC,  1'b1, ST_TOO_BIG, 3'd0, 30'd0},
            '{CMD_ALLOC, 32'd3,          1'b1, ST_PLACED,  3'd0, 30'd0},
            '{CMD_ALLOC, 32'd5,          1'b0, ST_PLACED,  3'd0, 30'd0}
        };
        caps = '{32'hFFFF_FFFF, 32'd4, 32'd64, 32'd1000, 32'd4096,
                 32'd5, 32'd0, PAGE_BYTES_RESET};
        caps[6] = $urandom_range(4, 65536);

        // reset
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (rows[r]) begin
            beat.cmd         = rows[r].cmd;
            beat.block_bytes = rows[r].bytes;
            typed_res        = '{rows[r].status, rows[r].page, rows[r].offset};
            offer(beat, rows[r].typed, typed_res);
        end
        drain();

        // random phases, one page size each
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_page_bytes(caps[ph]);
            for (int k = 0; k < PHASE_SZ; k++) begin
                if (k % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
                // one mid-phase pause until every result is back
                if (ph == 4 && k == 55) drain();
                offer(draw_beat(), 1'b0, '0);
            end
            drain();
        end

        repeat (16) @(posedge i_clk);
        if (bad_results == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side: random stall per beat, one long hold to back up the input
    initial begin : result_sink
        int   hold;
        t_out want;
        i_out_stall  = 1'b0;
        rx_quiet     = 1'b0;
        results_seen = 0;
        bad_results  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (results_seen % 40 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
            hold = rx_quiet ? 0 : $urandom_range(0, 8);
            if (results_seen == 300) hold = 120;
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            results_seen++;
            if (placements_due.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("result %0d arrived with nothing pending: status %0d page %0d offset %0h",
                             results_seen, o_out_data.status, o_out_data.page_index,
                             o_out_data.word_offset);
            end else begin
                want = placements_due.pop_front();
                if (o_out_data.status !== want.status ||
                    o_out_data.page_index !== want.page_index ||
                    o_out_data.word_offset !== want.word_offset) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("result %0d: want status %0d page %0d offset %0h, got %0d %0d %0h",
                                 results_seen, want.status, want.page_index, want.word_offset,
                                 o_out_data.status, o_out_data.page_index,
                                 o_out_data.word_offset);
                end
            end
        end
    end

    // run limit
    initial begin : run_limit
        #3000000;
        $display("FAIL");
        $finish;
    end

endmodule
